@@ sv/spq_pkg.sv @@
package spq_pkg;

	localparam int DEPTH   = 16;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PRIO_W  = 16;
	localparam int VALUE_W = 32;
	localparam int OCC_W   = 5;
	localparam int STAT_W  = 2;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 56;

	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_POP    = 1'b1;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic                      ins;
		logic                      pop;
		logic signed [PRIO_W-1:0]  prio;
		logic signed [VALUE_W-1:0] value;
	} spq_cmd_t;

	// What one cell shows to its neighbors.
	typedef struct packed {
		logic                      keep;
		logic signed [PRIO_W-1:0]  prio;
		logic signed [VALUE_W-1:0] value;
	} spq_link_t;

endpackage

@@ sv/spq_cell.sv @@
module spq_cell (
	input  logic               clk,
	input  spq_pkg::spq_cmd_t  cmd,
	input  logic               occupied,
	input  spq_pkg::spq_link_t left,
	input  spq_pkg::spq_link_t right,
	output spq_pkg::spq_link_t link
);
	import spq_pkg::*;

	logic signed [PRIO_W-1:0]  prio_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      keep;

	// An occupied entry that is not above the new priority stays, so equal
	// priorities keep their arrival order.
	assign keep = occupied && (prio_q <= cmd.prio);

	assign link.keep  = keep;
	assign link.prio  = prio_q;
	assign link.value = value_q;

	always_ff @(posedge clk) begin
		if (cmd.ins && !keep) begin
			if (left.keep) begin
				prio_q  <= cmd.prio;
				value_q <= cmd.value;
			end else begin
				prio_q  <= left.prio;
				value_q <= left.value;
			end
		end else if (cmd.pop) begin
			prio_q  <= right.prio;
			value_q <= right.value;
		end
	end

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// Output: a result is registered and shows on the master side in the cycle after its beat is taken.
// Throughput: one beat per cycle while the master side keeps taking results; every
// insert into a non-full queue and pop from a non-empty one updates all cells together.
// Reset: arst_n clears the entry count and the output valid; the stored entries
// are left as they are and are never read until written again.
module sorted_priority_queue_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [spq_pkg::S_DATA_W-1:0] s_tdata,  // in_priority[15:0], in_value[47:16]
	input  logic [0:0]                   s_tuser,  // func[0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [spq_pkg::M_DATA_W-1:0] m_tdata   // out_value[31:0], out_priority[47:32],
	                                               // status[49:48], occupancy[54:50], zero pad
);
	import spq_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	logic                accept;
	logic                full;
	logic                empty;
	logic                is_pop;
	spq_cmd_t            cmd;
	spq_link_t           links [DEPTH];
	logic [DEPTH-1:0]    occupied;
	logic [CNT_W-1:0]    count_next;
	logic [STAT_W-1:0]   status;
	logic [VALUE_W-1:0]  res_value;
	logic [PRIO_W-1:0]   res_prio;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_pop   = (s_tuser[0] == FUNC_POP);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	assign cmd.ins   = accept && !is_pop && !full;
	assign cmd.pop   = accept && is_pop && !empty;
	assign cmd.prio  = s_tdata[PRIO_W-1:0];
	assign cmd.value = s_tdata[PRIO_W +: VALUE_W];

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			spq_link_t left_in;
			spq_link_t right_in;

			assign occupied[i] = (CNT_W'(i) < count_q);

			if (i == 0) begin : g_head
				assign left_in = '{keep: 1'b1, prio: '0, value: '0};
			end else begin : g_mid
				assign left_in = links[i-1];
			end

			// The tail takes nothing on a pop; its old contents fall outside the count.
			if (i == DEPTH - 1) begin : g_tail
				assign right_in = links[i];
			end else begin : g_body
				assign right_in = links[i+1];
			end

			spq_cell u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.occupied (occupied[i]),
				.left     (left_in),
				.right    (right_in),
				.link     (links[i])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		status     = ST_DONE;
		res_value  = '0;
		res_prio   = '0;
		if (is_pop) begin
			if (empty) begin
				status = ST_EMPTY;
			end else begin
				count_next = count_q - CNT_W'(1);
				res_value  = links[0].value;
				res_prio   = links[0].prio;
			end
		end else begin
			if (full) begin
				status = ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {
				(M_DATA_W - VALUE_W - PRIO_W - STAT_W - OCC_W)'(0),
				OCC_W'(count_next),
				status,
				res_prio,
				res_value
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
